// ===== sv/yprgb_pkg.sv =====
// Package for the YUV pair to RGB converter: payload structs, mode codes,
// conversion coefficients and internal stage types. No dependencies.
package yprgb_pkg;

  localparam int SUM_W = 27;

  localparam logic MODE_FULL    = 1'b0;
  localparam logic MODE_LIMITED = 1'b1;

  // Full range, signed Q16 coefficients
  localparam logic signed [SUM_W-1:0] Q16_V_TO_R = SUM_W'(91881);
  localparam logic signed [SUM_W-1:0] Q16_U_TO_G = SUM_W'(22544);
  localparam logic signed [SUM_W-1:0] Q16_V_TO_G = SUM_W'(46793);
  localparam logic signed [SUM_W-1:0] Q16_U_TO_B = SUM_W'(116130);

  // Limited range BT.601 integer coefficients
  localparam logic signed [SUM_W-1:0] LIM_LUMA   = SUM_W'(298);
  localparam logic signed [SUM_W-1:0] LIM_V_TO_R = SUM_W'(409);
  localparam logic signed [SUM_W-1:0] LIM_U_TO_G = SUM_W'(100);
  localparam logic signed [SUM_W-1:0] LIM_V_TO_G = SUM_W'(208);
  localparam logic signed [SUM_W-1:0] LIM_U_TO_B = SUM_W'(516);
  localparam logic signed [SUM_W-1:0] LIM_ROUND  = SUM_W'(128);

  localparam logic signed [8:0] CHROMA_OFFSET = 9'sd128;
  localparam logic signed [8:0] LUMA_OFFSET   = 9'sd16;
  localparam int FULL_SHIFT = 16;
  localparam int LIM_SHIFT  = 8;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] luma_second;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } yuv_pair_t;

  typedef struct packed {
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
  } rgb_pair_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // Shared chroma contributions, one per channel, plus the mode they were built in
  typedef struct packed {
    logic                    mode;
    logic signed [SUM_W-1:0] red;
    logic signed [SUM_W-1:0] green;
    logic signed [SUM_W-1:0] blue;
  } chroma_terms_t;

endpackage

// ===== sv/yprgb_chroma.sv =====
// Shared chroma unit: forms the per-channel chroma products once per pair.
// Depends on yprgb_pkg.
module yprgb_chroma (
  input  logic                    clk_i,
  input  logic                    valid_i,
  input  logic                    mode_i,
  input  logic [7:0]              chroma_blue_i,
  input  logic [7:0]              chroma_red_i,
  output yprgb_pkg::chroma_terms_t terms_o
);
  import yprgb_pkg::*;

  logic signed [8:0]       d;
  logic signed [8:0]       e;
  logic signed [SUM_W-1:0] d_x;
  logic signed [SUM_W-1:0] e_x;
  chroma_terms_t           terms_d;
  chroma_terms_t           terms_q;

  assign d   = $signed({1'b0, chroma_blue_i}) - CHROMA_OFFSET;
  assign e   = $signed({1'b0, chroma_red_i}) - CHROMA_OFFSET;
  assign d_x = SUM_W'(d);
  assign e_x = SUM_W'(e);

  always_comb begin
    terms_d.mode = mode_i;
    if (mode_i == MODE_FULL) begin
      terms_d.red   = Q16_V_TO_R * e_x;
      terms_d.green = -(Q16_U_TO_G * d_x) - (Q16_V_TO_G * e_x);
      terms_d.blue  = Q16_U_TO_B * d_x;
    end else begin
      terms_d.red   = (LIM_V_TO_R * e_x) + LIM_ROUND;
      terms_d.green = LIM_ROUND - (LIM_U_TO_G * d_x) - (LIM_V_TO_G * e_x);
      terms_d.blue  = (LIM_U_TO_B * d_x) + LIM_ROUND;
    end
  end

  // hold products between requests
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      terms_q <= terms_d;
    end
  end

  assign terms_o = terms_q;

endmodule

// ===== sv/yprgb_lane.sv =====
// One pixel lane: registers the luma term, then adds the shared chroma terms,
// shifts and clamps each channel to 8 bits. Depends on yprgb_pkg.
module yprgb_lane (
  input  logic                     clk_i,
  input  logic                     valid_i,
  input  logic                     mode_i,
  input  logic [7:0]               luma_i,
  input  yprgb_pkg::chroma_terms_t terms_i,
  output yprgb_pkg::pixel_t        pixel_o
);
  import yprgb_pkg::*;

  logic signed [8:0]       c;
  logic signed [SUM_W-1:0] luma_d;
  logic signed [SUM_W-1:0] luma_q;

  function automatic logic [7:0] clamp_channel(input logic signed [SUM_W-1:0] t,
                                               input logic mode);
    logic [SUM_W-1:0] q;
    if (t[SUM_W-1]) begin
      return 8'd0;
    end
    q = (mode == MODE_FULL) ? (SUM_W'(t) >> FULL_SHIFT) : (SUM_W'(t) >> LIM_SHIFT);
    return (q > SUM_W'(255)) ? 8'hFF : q[7:0];
  endfunction

  assign c = $signed({1'b0, luma_i}) - LUMA_OFFSET;

  always_comb begin
    if (mode_i == MODE_FULL) begin
      luma_d = $signed(SUM_W'({luma_i, 16'h0000}));
    end else begin
      luma_d = LIM_LUMA * SUM_W'(c);
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      luma_q <= luma_d;
    end
  end

  assign pixel_o.red   = clamp_channel(luma_q + terms_i.red,   terms_i.mode);
  assign pixel_o.green = clamp_channel(luma_q + terms_i.green, terms_i.mode);
  assign pixel_o.blue  = clamp_channel(luma_q + terms_i.blue,  terms_i.mode);

endmodule

// ===== sv/yuv_pair_to_rgb_converter_core.sv =====
// YUV pair to RGB converter (BT.601, full or limited range), top level.
// Throughput: one pixel pair per cycle; busy stays low, so start may be high every cycle.
// The rate is set by the three-stage pipeline: input register, chroma/luma products,
// sum-and-clamp merged into the result register. The receiver cannot stall.
// Reset (rst_ni low, asynchronous) clears range_mode to full range and all valid flags.
module yuv_pair_to_rgb_converter_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write channel: range_mode
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_data_i,
  // command side
  input  logic                 start,
  output logic                 busy,
  input  yprgb_pkg::yuv_pair_t yuv_i,
  // result side
  output logic                 rgb_valid_o,
  output yprgb_pkg::rgb_pair_t rgb_o
);
  import yprgb_pkg::*;

  logic          range_mode_q;
  logic          accept;

  // stage 1: captured request
  logic          s1_valid_q;
  logic          s1_mode_q;
  yuv_pair_t     s1_yuv_q;

  // stage 2: products held in the chroma unit and the lanes
  logic          s2_valid_q;
  chroma_terms_t terms;
  pixel_t        pix_first;
  pixel_t        pix_second;

  // stage 3: merged result
  logic          rgb_valid_q;
  rgb_pair_t     rgb_q;

  // The pipeline never stalls: accept every request, take config at any time.
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_mode_q <= MODE_FULL;
    end else if (cfg_valid_i && cfg_ready_o) begin
      range_mode_q <= cfg_data_i;
    end
  end

  // Advance the valid flags one stage per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      rgb_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= accept;
      s2_valid_q  <= s1_valid_q;
      rgb_valid_q <= s2_valid_q;
    end
  end

  // Capture the request and the mode it runs in.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_yuv_q  <= yuv_i;
      s1_mode_q <= range_mode_q;
    end
  end

  // Chroma products are computed once and shared by both lanes.
  yprgb_chroma u_chroma (
    .clk_i         (clk_i),
    .valid_i       (s1_valid_q),
    .mode_i        (s1_mode_q),
    .chroma_blue_i (s1_yuv_q.chroma_blue),
    .chroma_red_i  (s1_yuv_q.chroma_red),
    .terms_o       (terms)
  );

  yprgb_lane u_lane_first (
    .clk_i   (clk_i),
    .valid_i (s1_valid_q),
    .mode_i  (s1_mode_q),
    .luma_i  (s1_yuv_q.luma_first),
    .terms_i (terms),
    .pixel_o (pix_first)
  );

  yprgb_lane u_lane_second (
    .clk_i   (clk_i),
    .valid_i (s1_valid_q),
    .mode_i  (s1_mode_q),
    .luma_i  (s1_yuv_q.luma_second),
    .terms_i (terms),
    .pixel_o (pix_second)
  );

  // Merge both lanes into the result register.
  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      rgb_q.red_first    <= pix_first.red;
      rgb_q.green_first  <= pix_first.green;
      rgb_q.blue_first   <= pix_first.blue;
      rgb_q.red_second   <= pix_second.red;
      rgb_q.green_second <= pix_second.green;
      rgb_q.blue_second  <= pix_second.blue;
    end
  end

  assign rgb_valid_o = rgb_valid_q;
  assign rgb_o       = rgb_q;

  // Every accepted request leads to a result strobe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 ##1 rgb_valid_o)
    else $error("accepted request produced no result strobe");

  // No result strobe without a matching earlier request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rgb_valid_o |-> $past(accept, 3))
    else $error("result strobe without a matching request");

  // Equal luma in both pixels of a pair gives identical pixels from both lanes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rgb_valid_o && ($past(yuv_i.luma_first, 3) == $past(yuv_i.luma_second, 3)))
    |-> (rgb_o.red_first == rgb_o.red_second && rgb_o.green_first == rgb_o.green_second
         && rgb_o.blue_first == rgb_o.blue_second))
    else $error("lanes disagree on equal luma");

endmodule

// ===== bench/yuv_pair_to_rgb_converter_core_test.sv =====
// Self-checking bench for yuv_pair_to_rgb_converter_core: directed and random pixel pairs
// in both range modes, each result checked against a built-in BT.601 predictor.
// Depends on yprgb_pkg and the converter RTL only.
module yuv_pair_to_rgb_converter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import yprgb_pkg::*;

  // Length of the tail watched for stray strobes after the final drain
  localparam int PIPE_LATENCY = 3;
  localparam int TAIL_CYCLES  = PIPE_LATENCY + 5;
  // Cycles with no request, result or register write before the run is declared hung
  localparam int STALL_LIMIT  = 2000;
  localparam int MAX_REPORTS  = 10;

  // Full range: signed Q16 coefficients
  localparam int FR_V_RED   = 91881;
  localparam int FR_U_GREEN = 22544;
  localparam int FR_V_GREEN = 46793;
  localparam int FR_U_BLUE  = 116130;
  // Limited range: BT.601 integer coefficients
  localparam int LR_LUMA    = 298;
  localparam int LR_V_RED   = 409;
  localparam int LR_U_GREEN = 100;
  localparam int LR_V_GREEN = 208;
  localparam int LR_U_BLUE  = 516;
  localparam int LR_ROUND   = 128;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic       cfg_data_i;
  logic       start;
  logic       busy;
  yuv_pair_t  yuv_i;
  logic       rgb_valid_o;
  rgb_pair_t  rgb_o;

  // Bench-side copy of range_mode, updated on every accepted register write
  logic       range_mode_model;
  rgb_pair_t  expected_rgb[$];

  int         sender_idle_pct;
  int         fail_count;
  int         stall_cycles;
  int         results_checked;
  int         pairs_full;
  int         pairs_limited;
  int         mode_writes;

  yuv_pair_to_rgb_converter_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .start       (start),
    .busy        (busy),
    .yuv_i       (yuv_i),
    .rgb_valid_o (rgb_valid_o),
    .rgb_o       (rgb_o)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Drop negative sums to 0, floor-shift the rest and saturate at 255
  function automatic logic [7:0] saturate_channel(int sum, int shift);
    int q;
    if (sum < 0) begin
      return 8'd0;
    end
    q = sum >>> shift;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic pixel_t convert_pixel(int luma, int du, int dv, logic mode);
    pixel_t px;
    int     base;
    if (mode == MODE_FULL) begin
      base     = luma * 65536;
      px.red   = saturate_channel(base + FR_V_RED * dv, FULL_SHIFT);
      px.green = saturate_channel(base - FR_U_GREEN * du - FR_V_GREEN * dv, FULL_SHIFT);
      px.blue  = saturate_channel(base + FR_U_BLUE * du, FULL_SHIFT);
    end else begin
      base     = LR_LUMA * (luma - 16);
      px.red   = saturate_channel(base + LR_V_RED * dv + LR_ROUND, LIM_SHIFT);
      px.green = saturate_channel(base - LR_U_GREEN * du - LR_V_GREEN * dv + LR_ROUND,
                                  LIM_SHIFT);
      px.blue  = saturate_channel(base + LR_U_BLUE * du + LR_ROUND, LIM_SHIFT);
    end
    return px;
  endfunction

  // Both pixels share the chroma pair; only luma differs
  function automatic rgb_pair_t predict_rgb_pair(yuv_pair_t px, logic mode);
    rgb_pair_t rgb;
    pixel_t    left;
    pixel_t    right;
    int        du;
    int        dv;
    du    = int'(px.chroma_blue) - 128;
    dv    = int'(px.chroma_red) - 128;
    left  = convert_pixel(int'(px.luma_first), du, dv, mode);
    right = convert_pixel(int'(px.luma_second), du, dv, mode);
    rgb.red_first    = left.red;
    rgb.green_first  = left.green;
    rgb.blue_first   = left.blue;
    rgb.red_second   = right.red;
    rgb.green_second = right.green;
    rgb.blue_second  = right.blue;
    return rgb;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and watchdog
  // ---------------------------------------------------------------------------

  task automatic compare_channel(string label, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      if (fail_count < MAX_REPORTS) begin
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, label, want, got);
      end
      fail_count++;
    end
  endtask

  // Sample everything on the rising edge, before the block's registers move.
  // Order inside one edge: retire a result, log a new request, track register writes.
  always @(posedge clk_i) begin : result_monitor
    rgb_pair_t want;
    logic      progress;
    if (rst_ni) begin
      progress = 1'b0;
      if (rgb_valid_o) begin
        progress = 1'b1;
        if (expected_rgb.size() == 0) begin
          if (fail_count < MAX_REPORTS) begin
            $display("[%0t] result with nothing expected: %h", $realtime, rgb_o);
          end
          fail_count++;
        end else begin
          want = expected_rgb.pop_front();
          results_checked++;
          compare_channel("red_first",    want.red_first,    rgb_o.red_first);
          compare_channel("green_first",  want.green_first,  rgb_o.green_first);
          compare_channel("blue_first",   want.blue_first,   rgb_o.blue_first);
          compare_channel("red_second",   want.red_second,   rgb_o.red_second);
          compare_channel("green_second", want.green_second, rgb_o.green_second);
          compare_channel("blue_second",  want.blue_second,  rgb_o.blue_second);
        end
      end
      if (start && !busy) begin
        progress = 1'b1;
        expected_rgb.push_back(predict_rgb_pair(yuv_i, range_mode_model));
        if (range_mode_model == MODE_FULL) begin
          pairs_full++;
        end else begin
          pairs_limited++;
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        progress = 1'b1;
        range_mode_model = cfg_data_i;
        mode_writes++;
      end
      stall_cycles = progress ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no request, result or register write for %0d cycles", STALL_LIMIT);
        $display("yuv_pair_to_rgb_converter_core_test NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Issue one request; idle each cycle with the set odds, then hold start until it is taken.
  // Start stays high on return so back-to-back requests need no gap.
  task automatic send_pair(yuv_pair_t px);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    yuv_i <= px;
    do @(posedge clk_i); while (busy);
  endtask

  // Drop start and wait until every outstanding result has been retired
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (expected_rgb.size() != 0);
  endtask

  // Write range_mode only with the pipeline empty
  task automatic write_range_mode(logic mode);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] edge_sample();
    case ($urandom_range(4))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd16;
      3:       return 8'd235;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly uniform pairs; one in five built from range edges to hit clamping often
  function automatic yuv_pair_t random_pair();
    yuv_pair_t px;
    if ($urandom_range(4) == 0) begin
      px.luma_first  = edge_sample();
      px.luma_second = edge_sample();
      px.chroma_blue = edge_sample();
      px.chroma_red  = edge_sample();
    end else begin
      px = yuv_pair_t'($urandom);
    end
    return px;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corner pairs, packed as {luma_first, luma_second, chroma_blue, chroma_red}
  task automatic run_corner_pairs();
    logic [31:0] corners[13];
    corners = '{
      32'h00000000,   // everything at zero: negative sums in limited range
      32'hFFFFFFFF,   // everything at max: saturation
      32'h00FF8080,   // neutral chroma, luma extremes
      32'hFF008080,
      32'h10EB8080,   // nominal black and white of limited range
      32'h000080FF,   // red driven up from black
      32'hFFFF8000,   // red driven down from white
      32'h0000FF80,   // blue driven up from black
      32'hFFFF0080,   // blue driven down from white
      32'h808000FF,   // green with opposing chroma extremes
      32'h8080FF00,
      32'h00FFFFFF,
      32'hAA5555AA    // alternating bit patterns
    };
    foreach (corners[i]) begin
      send_pair(yuv_pair_t'(corners[i]));
    end
  endtask

  // No register write yet: the block must convert in full range out of reset
  task automatic test_reset_mode();
    run_corner_pairs();
  endtask

  task automatic test_limited_range_corners();
    write_range_mode(MODE_LIMITED);
    run_corner_pairs();
  endtask

  // Flip the mode back and forth, rewriting the same value too
  task automatic test_mode_switching();
    logic modes[5];
    modes = '{MODE_FULL, MODE_LIMITED, MODE_LIMITED, MODE_FULL, MODE_LIMITED};
    foreach (modes[i]) begin
      write_range_mode(modes[i]);
      repeat (6) send_pair(random_pair());
    end
  endtask

  // Random pairs in four chunks with alternating mode; pause for a full drain now and then
  task automatic test_random_phase(int idle_pct, logic first_mode, int count);
    sender_idle_pct = idle_pct;
    for (int chunk = 0; chunk < 4; chunk++) begin
      write_range_mode(first_mode ^ chunk[0]);
      for (int n = 0; n < count / 4; n++) begin
        if ($urandom_range(59) == 0) begin
          wait_drained();
        end
        send_pair(random_pair());
      end
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_data_i       = 1'b0;
    start            = 1'b0;
    yuv_i            = '0;
    range_mode_model = MODE_FULL;
    sender_idle_pct  = 12;
    fail_count       = 0;
    stall_cycles     = 0;
    results_checked  = 0;
    pairs_full       = 0;
    pairs_limited    = 0;
    mode_writes      = 0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_mode();
    test_limited_range_corners();
    test_mode_switching();
    test_random_phase(12, MODE_FULL, 500);
    test_random_phase(77, MODE_LIMITED, 500);
    test_random_phase(0, MODE_FULL, 500);

    // Let the pipeline empty, then watch the tail for stray strobes
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("converted %0d full-range and %0d limited-range pairs over %0d mode writes;",
             pairs_full, pairs_limited, mode_writes);
    $display("%0d results checked, %0d channel mismatches or stray results",
             results_checked, fail_count);
    if (fail_count == 0 && expected_rgb.size() == 0) begin
      $display("yuv_pair_to_rgb_converter_core_test OK");
    end else begin
      $display("yuv_pair_to_rgb_converter_core_test NOT OK");
    end
    $finish;
  end

endmodule
